// ----- design/tcp_receive_reassembly_core_assert.svh -----
`ifndef TCP_RECEIVE_REASSEMBLY_CORE_ASSERT_SVH
`define TCP_RECEIVE_REASSEMBLY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while reset is asserted.
`define TRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reassembly check failed");

// Next-cycle implication, sampled on clk, ignored while reset is asserted.
`define TRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reassembly check failed");

`endif

// ----- design/trr_pkg.sv -----
package trr_pkg;

  // Reorder slots held in the mark memory.
  localparam int WINDOW_SLOTS = 64;
  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int DRN_W = $clog2(WINDOW_SLOTS + 1);

  localparam int SEQ_W = 32;
  localparam int SIZE_W = 16;
  localparam int SLOTS_W = 7;
  localparam int LIMIT_W = SIZE_W + SLOTS_W;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SEGMENT_SIZE = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SLOTS = 2'd1;

  localparam logic [SIZE_W-1:0] SEGMENT_SIZE_RST = 16'd1024;
  localparam logic [SLOTS_W-1:0] WINDOW_SLOTS_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_IN_ORDER = 2'd0,
    ST_BUFFERED = 2'd1,
    ST_OLD      = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

endpackage

// ----- design/tcp_receive_reassembly_core.sv -----
// TCP receive reassembly core.
// Input channel: in_segment_seq with in_valid/in_stall; one beat per arriving segment.
// Result channel: out_ack_seq, out_status, out_drained_count with out_valid/out_stall;
// exactly one result beat per input beat, in input order.
// Configuration: cfg_we/cfg_index/cfg_wdata write segment_size (0) and window_slots (1);
// write only while the core is idle.
// After reset the core sweeps the 64-entry mark memory, one entry a cycle, and holds
// in_stall high until the sweep is done. expected_seq restarts at zero.
// Steps from input accept to result: an old or beyond-window segment goes straight
// to emit; a buffered segment takes one 32-step serial divider pass for its slot,
// then one mark write; an in-order segment advances and divides the new expected
// number for its slot, then reads and clears each released slot in the mark memory,
// with no read after the 64th release, and divides again whenever the expected
// number wraps past 2^32.
// One item is in work at a time; the next is accepted as soon as the core returns to
// idle, even while the previous result is still held in the output register.
// If the receiver stalls, the result is held stable; a second finished result waits
// inside the core until the first is taken.
module tcp_receive_reassembly_core
  import trr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SEQ_W-1:0]     in_segment_seq,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SEQ_W-1:0]     out_ack_seq,
  output logic [1:0]           out_status,
  output logic [6:0]           out_drained_count
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_CLS, S_DIV, S_MARK, S_RD, S_CHK, S_EMIT
  } state_t;

  state_t               state_r;
  logic [SIZE_W-1:0]    seg_size_r;
  logic [SLOTS_W-1:0]   win_slots_r;
  logic [SEQ_W-1:0]     exp_r;
  logic [SEQ_W-1:0]     seq_r;
  logic [SLOT_W-1:0]    clr_r;
  logic [DRN_W-1:0]     drn_r;
  logic                 io_r;
  status_t              status_r;
  logic [SEQ_W-1:0]     div_n_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SLOTS_W-1:0]   acc_r;
  logic [4:0]           cnt_r;
  logic                 out_valid_r;
  logic [SEQ_W-1:0]     out_ack_r;
  status_t              out_status_r;
  logic [6:0]           out_drn_r;

  logic                 marks [WINDOW_SLOTS];
  logic                 mem_q_r;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_wa;
  logic                 mem_wd;
  logic                 mem_re;

  logic [SIZE_W-1:0]    size_eff;
  logic [SLOTS_W-1:0]   slots_eff;
  logic [SEQ_W-1:0]     seq_gap;
  logic [LIMIT_W-1:0]   limit;
  logic [SIZE_W:0]      trial;
  logic                 qbit;
  logic [SIZE_W-1:0]    rem_nxt;
  logic [SLOTS_W:0]     acc_t;
  logic [SLOTS_W-1:0]   acc_nxt;
  logic [SLOTS_W:0]     acc_inc;
  logic [SEQ_W:0]       exp_sum;
  logic [SLOT_W-1:0]    slot_idx;
  logic                 in_acc;
  logic                 out_acc;
  logic                 out_load;

  assign size_eff = (seg_size_r == '0) ? SIZE_W'(1) : seg_size_r;

  always_comb begin
    if (win_slots_r == '0) begin
      slots_eff = SLOTS_W'(1);
    end else if (32'(win_slots_r) > WINDOW_SLOTS) begin
      slots_eff = SLOTS_W'(WINDOW_SLOTS);
    end else begin
      slots_eff = win_slots_r;
    end
  end

  assign seq_gap = seq_r - exp_r;
  assign limit   = LIMIT_W'(slots_eff - SLOTS_W'(1)) * LIMIT_W'(size_eff);

  // One restoring-division step; the quotient bit also folds into the slot modulus.
  assign trial   = {rem_r, div_n_r[SEQ_W-1]};
  assign qbit    = (trial >= {1'b0, size_eff});
  assign rem_nxt = qbit ? SIZE_W'(trial - {1'b0, size_eff}) : trial[SIZE_W-1:0];
  assign acc_t   = {acc_r, qbit};
  assign acc_nxt = (acc_t >= {1'b0, slots_eff}) ? SLOTS_W'(acc_t - {1'b0, slots_eff})
                                                : acc_t[SLOTS_W-1:0];
  assign acc_inc = {1'b0, acc_r} + (SLOTS_W+1)'(1);
  assign exp_sum = {1'b0, exp_r} + (SEQ_W+1)'(size_eff);
  assign slot_idx = SLOT_W'(acc_r);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_idx;
    mem_wd = 1'b0;
    mem_re = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
      end
      S_MARK: begin
        mem_we = 1'b1;
        mem_wd = 1'b1;
      end
      S_RD:  mem_re = (drn_r != DRN_W'(WINDOW_SLOTS));
      S_CHK: mem_we = mem_q_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      marks[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= marks[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      seg_size_r  <= SEGMENT_SIZE_RST;
      win_slots_r <= WINDOW_SLOTS_RST;
      exp_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEGMENT_SIZE: seg_size_r  <= cfg_wdata;
          CFG_WINDOW_SLOTS: win_slots_r <= cfg_wdata[SLOTS_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_ack_r    <= exp_r - SEQ_W'(size_eff);
        out_status_r <= status_r;
        out_drn_r    <= 7'(drn_r);
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + SLOT_W'(1);
          if (clr_r == SLOT_W'(WINDOW_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            seq_r   <= in_segment_seq;
            state_r <= S_CLS;
          end
        end
        S_CLS: begin
          drn_r <= '0;
          rem_r <= '0;
          acc_r <= '0;
          cnt_r <= '0;
          if (seq_gap == '0) begin
            // advance, then divide the new expected number for its slot
            io_r     <= 1'b1;
            status_r <= ST_IN_ORDER;
            exp_r    <= exp_sum[SEQ_W-1:0];
            div_n_r  <= exp_sum[SEQ_W-1:0];
            state_r  <= S_DIV;
          end else if (!seq_gap[SEQ_W-1] && seq_gap <= SEQ_W'(limit)) begin
            io_r     <= 1'b0;
            status_r <= ST_BUFFERED;
            div_n_r  <= seq_r;
            state_r  <= S_DIV;
          end else if (!seq_gap[SEQ_W-1]) begin
            status_r <= ST_BEYOND;
            state_r  <= S_EMIT;
          end else begin
            status_r <= ST_OLD;
            state_r  <= S_EMIT;
          end
        end
        S_DIV: begin
          rem_r   <= rem_nxt;
          acc_r   <= acc_nxt;
          div_n_r <= {div_n_r[SEQ_W-2:0], 1'b0};
          cnt_r   <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= io_r ? S_RD : S_MARK;
          end
        end
        S_MARK: state_r <= S_EMIT;
        S_RD: begin
          state_r <= (drn_r == DRN_W'(WINDOW_SLOTS)) ? S_EMIT : S_CHK;
        end
        S_CHK: begin
          if (!mem_q_r) begin
            state_r <= S_EMIT;
          end else begin
            drn_r <= drn_r + DRN_W'(1);
            exp_r <= exp_sum[SEQ_W-1:0];
            if (exp_sum[SEQ_W]) begin
              // wrapped past 2^32: the quotient no longer steps by one, divide again
              div_n_r <= exp_sum[SEQ_W-1:0];
              rem_r   <= '0;
              acc_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_DIV;
            end else begin
              acc_r   <= (acc_inc == {1'b0, slots_eff}) ? '0 : acc_inc[SLOTS_W-1:0];
              state_r <= S_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ack_seq       = out_ack_r;
  assign out_status        = out_status_r;
  assign out_drained_count = out_drn_r;

`include "tcp_receive_reassembly_core_assert.svh"

  `TRR_ASSERT_NOW(a_drn_only_in_order, out_valid_r && out_status_r != ST_IN_ORDER, out_drn_r == 7'd0)
  `TRR_ASSERT_NOW(a_drain_bounded, state_r == S_CHK, drn_r < DRN_W'(WINDOW_SLOTS))
  `TRR_ASSERT_NEXT(a_div_exit, state_r == S_DIV, state_r == S_DIV || state_r == S_MARK || state_r == S_RD)
  `TRR_ASSERT_NEXT(a_accept_starts, in_acc, state_r == S_CLS)

endmodule

// ----- bench/reassembly_watch.sv -----
`timescale 1ns / 100ps

module reassembly_watch
  import trr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [SEQ_W-1:0]   in_segment_seq,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [SEQ_W-1:0]   out_ack_seq,
  input  logic [1:0]         out_status,
  input  logic [6:0]         out_drained_count,
  output int                 mismatch_count,
  output int                 acks_waiting,
  output int                 acks_checked,
  output logic [3:0][31:0]   status_hits,
  output int                 longest_drain,
  output logic [SEQ_W-1:0]   next_expected
);

  typedef struct packed {
    logic [SEQ_W-1:0] ack_seq;
    status_t          status;
    logic [6:0]       drained;
  } ack_t;

  ack_t                    ack_queue[$];
  logic [SIZE_W-1:0]       seg_size = SEGMENT_SIZE_RST;
  logic [SLOTS_W-1:0]      win_slots = WINDOW_SLOTS_RST;
  logic [SEQ_W-1:0]        rcv_next = '0;
  logic [WINDOW_SLOTS-1:0] marks = '0;
  int                      bad_fields = 0;
  int                      acks_seen = 0;
  int                      max_run = 0;
  int                      hits [4] = '{0, 0, 0, 0};

  assign mismatch_count = bad_fields;
  assign acks_checked = acks_seen;
  assign longest_drain = max_run;
  assign status_hits = {hits[3], hits[2], hits[1], hits[0]};

  // A zero size steps by one.
  function automatic logic [SEQ_W-1:0] size_now();
    return (seg_size == '0) ? 32'd1 : {16'd0, seg_size};
  endfunction

  // Clamp the slot count into 1..WINDOW_SLOTS.
  function automatic int slots_now();
    if (win_slots == '0) return 1;
    if (win_slots > WINDOW_SLOTS) return WINDOW_SLOTS;
    return int'(win_slots);
  endfunction

  function automatic int slot_of_seq(input logic [SEQ_W-1:0] seq);
    return int'((seq / size_now()) % 32'(slots_now()));
  endfunction

  // Fold one arriving segment into the window and queue the ack it earns.
  task automatic fold_segment(input logic [SEQ_W-1:0] seq);
    ack_t             r;
    logic [SEQ_W-1:0] sz;
    logic [SEQ_W-1:0] seq_gap;
    logic [SEQ_W-1:0] reach;
    int               run;
    sz = size_now();
    seq_gap = seq - rcv_next;
    reach = 32'(slots_now() - 1) * sz;
    run = 0;
    if (seq_gap == '0) begin
      r.status = ST_IN_ORDER;
      rcv_next = rcv_next + sz;
      while (run < WINDOW_SLOTS && marks[slot_of_seq(rcv_next)]) begin
        marks[slot_of_seq(rcv_next)] = 1'b0;
        rcv_next = rcv_next + sz;
        run++;
      end
    end else if (!seq_gap[SEQ_W-1]) begin
      if (seq_gap <= reach) begin
        r.status = ST_BUFFERED;
        marks[slot_of_seq(seq)] = 1'b1;
      end else begin
        r.status = ST_BEYOND;
      end
    end else begin
      r.status = ST_OLD;
    end
    r.drained = 7'(run);
    r.ack_seq = rcv_next - sz;
    ack_queue.push_back(r);
  endtask

  always @(posedge clk) begin
    ack_t want;
    if (!rst_n) begin
      seg_size = SEGMENT_SIZE_RST;
      win_slots = WINDOW_SLOTS_RST;
      rcv_next = '0;
      marks = '0;
      ack_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEGMENT_SIZE: seg_size = cfg_wdata;
          CFG_WINDOW_SLOTS: win_slots = cfg_wdata[SLOTS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fold_segment(in_segment_seq);
      if (out_valid && !out_stall) begin
        if (ack_queue.size() == 0) begin
          $error("ack beat with nothing pending: ack_seq %h status %0d drained %0d",
                 out_ack_seq, out_status, out_drained_count);
          bad_fields++;
        end else begin
          want = ack_queue.pop_front();
          acks_seen++;
          hits[want.status]++;
          if (int'(want.drained) > max_run) max_run = int'(want.drained);
          if (out_ack_seq !== want.ack_seq) begin
            $error("ack_seq: expected %h, got %h", want.ack_seq, out_ack_seq);
            bad_fields++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %s, got %0d", want.status.name(), out_status);
            bad_fields++;
          end
          if (out_drained_count !== want.drained) begin
            $error("drained_count: expected %0d, got %0d", want.drained, out_drained_count);
            bad_fields++;
          end
        end
      end
    end
    acks_waiting <= ack_queue.size();
    next_expected <= rcv_next;
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import trr_pkg::*;

  localparam int SEGMENT_TARGET = 1300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_SEGMENT_SIZE;
  logic [SIZE_W-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SEQ_W-1:0]   in_segment_seq = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SEQ_W-1:0]   out_ack_seq;
  logic [1:0]         out_status;
  logic [6:0]         out_drained_count;

  int                 mismatches;
  int                 waiting;
  int                 checked;
  logic [3:0][31:0]   hits;
  int                 longest;
  logic [SEQ_W-1:0]   rcv_next;

  logic [SIZE_W-1:0]  size_reg = SEGMENT_SIZE_RST;
  logic [SIZE_W-1:0]  slots_reg = {9'd0, WINDOW_SLOTS_RST};
  int                 segments_sent = 0;
  int                 settings_used = 1;
  int                 burst_left = 0;

  // Window edges and sign boundary, taken from a fresh receiver.
  logic [SEQ_W-1:0] opening [14] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FC00, 32'h0000_FC01, 32'hFFFF_FFFF,
    32'h0000_0800, 32'h0000_0400, 32'h0000_0000, 32'h0000_0000, 32'h0000_0C01,
    32'h0000_0C00, 32'h0000_1000, 32'h8000_0FFF, 32'h0000_2000
  };

  tcp_receive_reassembly_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_segment_seq    (in_segment_seq),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ack_seq       (out_ack_seq),
    .out_status        (out_status),
    .out_drained_count (out_drained_count)
  );

  reassembly_watch u_watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_segment_seq    (in_segment_seq),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ack_seq       (out_ack_seq),
    .out_status        (out_status),
    .out_drained_count (out_drained_count),
    .mismatch_count    (mismatches),
    .acks_waiting      (waiting),
    .acks_checked      (checked),
    .status_hits       (hits),
    .longest_drain     (longest),
    .next_expected     (rcv_next)
  );

  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver back-pressure: switch between free flow, scattered stalls and long holds.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(64, 512);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(1, 12);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  function automatic logic [SEQ_W-1:0] size_step();
    return (size_reg == '0) ? 32'd1 : {16'd0, size_reg};
  endfunction

  function automatic int slot_span();
    if (slots_reg[SLOTS_W-1:0] == '0) return 1;
    if (slots_reg[SLOTS_W-1:0] > WINDOW_SLOTS) return WINDOW_SLOTS;
    return int'(slots_reg[SLOTS_W-1:0]);
  endfunction

  // One beat, in bursts with random gaps between them.
  task automatic send_segment(input logic [SEQ_W-1:0] seq);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (in_valid && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_segment_seq <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    segments_sent++;
  endtask

  // Hold the sender until every ack is back and the core is ready again.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0 || in_stall);
  endtask

  task automatic apply_settings(input logic [SIZE_W-1:0] sz, input logic [SIZE_W-1:0] sl);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEGMENT_SIZE;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_SLOTS;
    cfg_wdata <= sl;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = sz;
    slots_reg = sl;
    settings_used++;
  endtask

  // Noise around the current window: old, past the edge, far ahead, off-grid.
  function automatic logic [SEQ_W-1:0] stray_segment(input logic [SEQ_W-1:0] base,
                                                      input logic [SEQ_W-1:0] reach);
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return base - $urandom_range(32'h8000_0000, 1);
      2: return base + reach + $urandom_range(1, 4);
      3: return base + $urandom_range(32'h7FFF_FFFF, reach + 1);
      4: return base + $urandom_range(reach, 0);
      5: return base + reach;
      default: return base + ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
    endcase
  endfunction

  // A run of segments from the current expected number, shuffled, with
  // optional noise, a missing head, or an extra mark in the head's own slot.
  task automatic reorder_block(input int shape);
    logic [SEQ_W-1:0] plan[$];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] sz;
    logic [SEQ_W-1:0] reach;
    logic [SEQ_W-1:0] tmp;
    int               n;
    int               k;
    int               j;
    int               first;
    settle();
    base = rcv_next;
    sz = size_step();
    n = slot_span();
    reach = 32'(n - 1) * sz;
    k = (shape >= 6 || $urandom_range(0, 3) == 0) ? n : $urandom_range(1, n);
    first = ($urandom_range(0, 7) == 0) ? 1 : 0;
    for (int i = first; i < k; i++) plan.push_back(base + 32'(i) * sz);
    for (int i = plan.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = plan[i];
      plan[i] = plan[j];
      plan[j] = tmp;
    end
    if (shape == 6 && n > 1 && sz > 1) plan.push_front(base + $urandom_range(sz - 1, 1));
    foreach (plan[i]) begin
      if ($urandom_range(0, 7) == 0) send_segment(stray_segment(base, reach));
      send_segment(plan[i]);
    end
  endtask

  task automatic noise_block();
    logic [SEQ_W-1:0] reach;
    settle();
    reach = 32'(slot_span() - 1) * size_step();
    repeat ($urandom_range(8, 24)) send_segment(stray_segment(rcv_next, reach));
  endtask

  initial begin
    int               phase;
    int               budget;
    int               shape;
    logic [SIZE_W-1:0] sz;
    logic [SIZE_W-1:0] sl;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    settle();
    foreach (opening[i]) send_segment(opening[i]);

    phase = 0;
    while (segments_sent < SEGMENT_TARGET) begin
      case (phase)
        0: begin sz = 16'd1;     sl = 16'd1;     end
        1: begin sz = 16'd65535; sl = 16'd64;    end
        2: begin sz = 16'd0;     sl = 16'd5;     end
        3: begin sz = 16'd700;   sl = 16'd0;     end
        4: begin sz = 16'd1024;  sl = 16'd127;   end
        5: begin sz = 16'd3;     sl = 16'hFF83;  end
        6: begin sz = 16'd1024;  sl = 16'd64;    end
        7: begin sz = 16'd1;     sl = 16'd64;    end
        default: begin
          sz = $urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(1, 65535));
          sl = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 127))
                                            : 16'($urandom_range(1, 64));
        end
      endcase
      apply_settings(sz, sl);
      budget = segments_sent + $urandom_range(60, 140);
      while (segments_sent < budget) begin
        shape = $urandom_range(0, 9);
        if (shape == 7) noise_block();
        else reorder_block(shape);
      end
      phase++;
    end

    settle();
    repeat (250) @(posedge clk);
    $display("Run covered %0d segments under %0d register settings, %0d acks checked.",
             segments_sent, settings_used, checked);
    $display("Acks by kind: in order %0d, buffered %0d, old %0d, beyond window %0d; "
             , hits[0], hits[1], hits[2], hits[3],
             "longest release run %0d slots.", longest);
    if (mismatches == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/trr_pkg.sv
design/tcp_receive_reassembly_core.sv
bench/reassembly_watch.sv
bench/testbench.sv
